FILE: src/srwr_pkg.sv
// shared types and constants of the selective-repeat receive window
// no dependencies; compiled before every other file of the block
package srwr_pkg;

  localparam int OFF_W  = 32;
  localparam int LEN_W  = 11;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_HELD = 2'd0,
    KIND_DROP = 2'd1,
    KIND_REL  = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_PLACE,
    ST_DRAIN
  } ctrl_state_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_DROP,
    ACT_HOLD,
    ACT_REL_IN,
    ACT_REL_MEM
  } dp_act_e;

  typedef struct packed {
    logic    cap;
    logic    calc;
    logic    div;
    dp_act_e act;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic at_base;
    logic next_valid;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: src/srwr_if.sv
// segment request and result request channel interfaces
// depends on srwr_pkg
interface srwr_seg_if #(
  parameter int TAG_BITS = 8
);
  import srwr_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFF_W-1:0]    seg_offset;
  logic [LEN_W-1:0]    seg_length;
  logic [TAG_BITS-1:0] payload_tag;

  modport source (output valid, seg_offset, seg_length, payload_tag, input ready);
  modport sink   (input valid, seg_offset, seg_length, payload_tag, output ready);
endinterface

interface srwr_res_if #(
  parameter int TAG_BITS = 8
);
  import srwr_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [TAG_BITS-1:0] out_tag;
  logic [LEN_W-1:0]    out_length;
  logic                transfer_done;
  logic                last;

  modport source (output valid, result_kind, out_tag, out_length, transfer_done, last,
                  input ready);
  modport sink   (input valid, result_kind, out_tag, out_length, transfer_done, last,
                  output ready);
endinterface

FILE: src/srwr_ctrl.sv
// control state machine of the receive window
// depends on srwr_pkg; drives the datapath commands
module srwr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srwr_pkg::dp_sts_t sts_i,
  output srwr_pkg::dp_cmd_t cmd_o
);
  import srwr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: state_d = ST_DIV;
      ST_DIV:  state_d = ST_PLACE;
      ST_PLACE: begin
        if (sts_i.out_free) begin
          if (sts_i.drop || !sts_i.at_base || !sts_i.next_valid) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (sts_i.out_free && !sts_i.next_valid) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.cap    = 1'b0;
    cmd_o.calc   = 1'b0;
    cmd_o.div    = 1'b0;
    cmd_o.act    = ACT_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.cap  = in_valid_i;
      end
      ST_CALC: cmd_o.calc = 1'b1;
      ST_DIV:  cmd_o.div  = 1'b1;
      ST_PLACE: begin
        if (sts_i.out_free) begin
          if (sts_i.drop) begin
            cmd_o.act = ACT_DROP;
          end else if (!sts_i.at_base) begin
            cmd_o.act = ACT_HOLD;
          end else begin
            cmd_o.act = ACT_REL_IN;
          end
        end
      end
      ST_DRAIN: begin
        if (sts_i.out_free) cmd_o.act = ACT_REL_MEM;
      end
      default: cmd_o.act = ACT_NONE;
    endcase
  end

endmodule

FILE: src/srwr_dp.sv
// datapath of the receive window: slot math, slot store, delivery counter
// and result register; depends on srwr_pkg, commanded by srwr_ctrl
module srwr_dp #(
  parameter int WINDOW_SLOTS  = 64,
  parameter int SEGMENT_BYTES = 1024,
  parameter int TAG_BITS      = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [srwr_pkg::OFF_W-1:0]  cfg_wdata_i,
  input  logic [srwr_pkg::OFF_W-1:0]  seg_offset_i,
  input  logic [srwr_pkg::LEN_W-1:0]  seg_length_i,
  input  logic [TAG_BITS-1:0]         payload_tag_i,
  input  srwr_pkg::dp_cmd_t           cmd_i,
  output srwr_pkg::dp_sts_t           sts_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [srwr_pkg::KIND_W-1:0] res_kind_o,
  output logic [TAG_BITS-1:0]         res_tag_o,
  output logic [srwr_pkg::LEN_W-1:0]  res_length_o,
  output logic                        res_done_o,
  output logic                        res_last_o
);
  import srwr_pkg::*;

  localparam int SLOT_W    = $clog2(WINDOW_SLOTS);
  localparam int WIN_BYTES = WINDOW_SLOTS * SEGMENT_BYTES;
  localparam int DIFF_W    = (WIN_BYTES > 2) ? $clog2(WIN_BYTES) : 1;
  // round-up reciprocal, exact for every offset inside the window span
  localparam int SHIFT     = DIFF_W + $clog2(SEGMENT_BYTES);
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES);
  localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'(RECIP_L);
  localparam int PROD_W    = DIFF_W + SHIFT + 1;

  logic [OFF_W-1:0]    total_q;
  logic [OFF_W-1:0]    delivered_q;
  logic [SLOT_W-1:0]   base_q, base_d;
  logic [WINDOW_SLOTS-1:0] valid_q;

  logic [OFF_W-1:0]    off_q;
  logic [LEN_W-1:0]    len_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                drop_q;
  logic [DIFF_W-1:0]   diff_q;
  logic [SLOT_W-1:0]   idx_q;

  logic [TAG_BITS-1:0] mem_tag [WINDOW_SLOTS];
  logic [LEN_W-1:0]    mem_len [WINDOW_SLOTS];
  logic [TAG_BITS-1:0] rd_tag_q;
  logic [LEN_W-1:0]    rd_len_q;

  logic                out_valid_q;
  logic [KIND_W-1:0]   out_kind_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic [LEN_W-1:0]    out_len_q;
  logic                out_done_q;
  logic                out_last_q;

  logic [OFF_W-1:0]    diff_full;
  logic                seg_bad;
  logic [PROD_W-1:0]   prod;
  logic [SLOT_W:0]     slot_sum;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   next_base;
  logic                is_rel;
  logic                load;
  logic [TAG_BITS-1:0] rel_tag;
  logic [LEN_W-1:0]    rel_len;
  logic [OFF_W-1:0]    deliv_sum;
  logic [KIND_W-1:0]   kind_d;

  // range check of the offset against the window, and reciprocal multiply of the distance
  always_comb begin
    diff_full = off_q - delivered_q;
    seg_bad   = ((off_q == '0) && (len_q == '0)) || (off_q < delivered_q) ||
                (diff_full >= OFF_W'(WIN_BYTES));
    prod      = PROD_W'(diff_q) * PROD_W'(RECIP);
  end

  // slot placement and drain bookkeeping
  always_comb begin
    slot_sum  = {1'b0, base_q} + {1'b0, idx_q};
    slot      = (slot_sum >= (SLOT_W + 1)'(WINDOW_SLOTS)) ?
                SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW_SLOTS)) : slot_sum[SLOT_W-1:0];
    next_base = (base_q == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : base_q + 1'b1;
    is_rel    = (cmd_i.act == ACT_REL_IN) || (cmd_i.act == ACT_REL_MEM);
    load      = (cmd_i.act != ACT_NONE);
    rel_tag   = (cmd_i.act == ACT_REL_MEM) ? rd_tag_q : tag_q;
    rel_len   = (cmd_i.act == ACT_REL_MEM) ? rd_len_q : len_q;
    deliv_sum = delivered_q + OFF_W'(rel_len);
    base_d    = is_rel ? next_base : base_q;
    case (cmd_i.act)
      ACT_HOLD:                kind_d = KIND_HELD;
      ACT_REL_IN, ACT_REL_MEM: kind_d = KIND_REL;
      default:                 kind_d = KIND_DROP;
    endcase
  end

  always_comb begin
    sts_o.drop       = drop_q || valid_q[slot];
    sts_o.at_base    = (slot == base_q);
    sts_o.next_valid = valid_q[next_base];
    sts_o.out_free   = !out_valid_q || res_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      delivered_q <= '0;
      base_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) total_q <= cfg_wdata_i;
      if (is_rel) delivered_q <= deliv_sum;
      base_q <= base_d;
      if (cmd_i.act == ACT_HOLD) valid_q[slot] <= 1'b1;
      if (cmd_i.act == ACT_REL_MEM) valid_q[base_q] <= 1'b0;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      off_q <= seg_offset_i;
      len_q <= seg_length_i;
      tag_q <= payload_tag_i;
    end
    if (cmd_i.calc) begin
      drop_q <= seg_bad;
      diff_q <= diff_full[DIFF_W-1:0];
    end
    if (cmd_i.div) idx_q <= prod[SHIFT +: SLOT_W];
    if (load) begin
      out_kind_q <= kind_d;
      out_tag_q  <= is_rel ? rel_tag : tag_q;
      out_len_q  <= is_rel ? rel_len : len_q;
      out_done_q <= is_rel ? (deliv_sum == total_q) : (delivered_q == total_q);
      out_last_q <= is_rel ? !valid_q[next_base] : 1'b1;
    end
  end

  // slot store, read port follows the base that the next cycle will hold
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_HOLD) begin
      mem_tag[slot] <= tag_q;
      mem_len[slot] <= len_q;
    end
    rd_tag_q <= mem_tag[base_d];
    rd_len_q <= mem_len[base_d];
  end

  assign res_valid_o  = out_valid_q;
  assign res_kind_o   = out_kind_q;
  assign res_tag_o    = out_tag_q;
  assign res_length_o = out_len_q;
  assign res_done_o   = out_done_q;
  assign res_last_o   = out_last_q;

endmodule

FILE: src/sliding_window_reorder_receiver_unit.sv
// top level of the selective-repeat receive window
// depends on srwr_pkg, srwr_if, srwr_ctrl and srwr_dp
//
// usage
// - seg_i carries arriving segment requests: byte offset, length, payload tag
// - res_o carries result requests: held (0), dropped (1) or released in order (2),
//   with the tag and length concerned, a transfer-done flag and a last flag
//   on the final result of each segment
// - cfg_we_i / cfg_wdata_i write the total transfer length; write only while idle
// - a segment is taken in the idle state, then checked, divided into a slot index by a
//   reciprocal multiply and placed: its first result is registered on placement, and
//   the next segment is taken only once the block is back in idle, so a new segment
//   is not taken before every result of the last one has been registered
// - each further in-order release is paced by the single read port of the slot store
//   (one slot per cycle while res_o is ready)
// - res_o is a result register: while it is stalled the block keeps taking a
//   segment and working it up to placement, then waits for the register to free
// - reset clears the delivered count, the window base, all slot valid bits and
//   the total length; the slot store itself needs no clearing
module sliding_window_reorder_receiver_unit #(
  parameter int WINDOW_SLOTS  = 64,
  parameter int SEGMENT_BYTES = 1024,
  parameter int TAG_BITS      = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [srwr_pkg::OFF_W-1:0] cfg_wdata_i,
  srwr_seg_if.sink                   seg_i,
  srwr_res_if.source                 res_o
);
  import srwr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  // controller: sequences check, divide, place and drain
  srwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (seg_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: window state, slot store and result register
  srwr_dp #(
    .WINDOW_SLOTS  (WINDOW_SLOTS),
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .TAG_BITS      (TAG_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .seg_offset_i  (seg_i.seg_offset),
    .seg_length_i  (seg_i.seg_length),
    .payload_tag_i (seg_i.payload_tag),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .res_kind_o    (res_o.result_kind),
    .res_tag_o     (res_o.out_tag),
    .res_length_o  (res_o.out_length),
    .res_done_o    (res_o.transfer_done),
    .res_last_o    (res_o.last)
  );

  assign seg_i.ready = in_ready;

endmodule

FILE: test/srwr_window_checker.sv
// scoreboard for the selective-repeat receive window: watches the config port and both
// request channels, keeps its own window state and checks each result request in order
// depends on srwr_pkg and srwr_if
module srwr_window_checker #(
  parameter int WINDOW_SLOTS  = 64,
  parameter int SEGMENT_BYTES = 1024,
  parameter int TAG_BITS      = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [srwr_pkg::OFF_W-1:0] cfg_wdata_i,
  srwr_seg_if                        seg_i,
  srwr_res_if                        res_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import srwr_pkg::*;

  typedef struct packed {
    result_kind_e        kind;
    logic [TAG_BITS-1:0] tag;
    logic [LEN_W-1:0]    len;
    logic                done;
    logic                last;
  } window_result_t;

  logic [OFF_W-1:0]    total_len;
  logic [OFF_W-1:0]    delivered;
  int                  base;
  logic                slot_held [WINDOW_SLOTS];
  logic [TAG_BITS-1:0] slot_tag  [WINDOW_SLOTS];
  logic [LEN_W-1:0]    slot_len  [WINDOW_SLOTS];
  window_result_t      due_results [$];
  window_result_t      got;
  window_result_t      want;
  int                  mismatches;

  function automatic window_result_t make_result(input result_kind_e kind,
                                                 input logic [TAG_BITS-1:0] tag,
                                                 input logic [LEN_W-1:0] len);
    window_result_t r;
    r.kind = kind;
    r.tag  = tag;
    r.len  = len;
    r.done = (delivered == total_len);
    r.last = 1'b0;
    return r;
  endfunction

  function automatic string show(input window_result_t r);
    return $sformatf("kind %0d tag %02h len %0d done %0b last %0b",
                     r.kind, r.tag, r.len, r.done, r.last);
  endfunction

  // place one arriving segment and queue every result it causes
  task automatic admit_segment(input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len,
                               input logic [TAG_BITS-1:0] tag);
    window_result_t   burst [$];
    logic [OFF_W-1:0] idx;
    int               slot;
    bit               dropped;
    slot    = 0;
    dropped = (off == '0 && len == '0) || (off < delivered);
    idx     = (off - delivered) / SEGMENT_BYTES;
    if (!dropped && idx >= WINDOW_SLOTS) dropped = 1'b1;
    if (!dropped) begin
      slot = base + int'(idx);
      if (slot >= WINDOW_SLOTS) slot -= WINDOW_SLOTS;
      if (slot_held[slot]) dropped = 1'b1;
    end
    if (dropped) begin
      burst.push_back(make_result(KIND_DROP, tag, len));
    end else begin
      slot_held[slot] = 1'b1;
      slot_tag[slot]  = tag;
      slot_len[slot]  = len;
      if (slot != base) burst.push_back(make_result(KIND_HELD, tag, len));
      // in-order drain from the base slot
      while (slot_held[base] && burst.size() < WINDOW_SLOTS) begin
        delivered       += OFF_W'(slot_len[base]);
        slot_held[base]  = 1'b0;
        burst.push_back(make_result(KIND_REL, slot_tag[base], slot_len[base]));
        base = (base + 1 >= WINDOW_SLOTS) ? 0 : base + 1;
      end
    end
    burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) due_results.push_back(burst[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_len  = '0;
      delivered  = '0;
      base       = 0;
      foreach (slot_held[i]) slot_held[i] = 1'b0;
      due_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.kind = result_kind_e'(res_i.result_kind);
        got.tag  = res_i.out_tag;
        got.len  = res_i.out_length;
        got.done = res_i.transfer_done;
        got.last = res_i.last;
        if (due_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: %s", show(got));
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.tag !== want.tag || got.len !== want.len ||
              got.done !== want.done || got.last !== want.last) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected %s, got %s", show(want), show(got));
            end
            mismatches++;
          end
        end
      end
      if (cfg_we_i) total_len = cfg_wdata_i;
      if (seg_i.valid && seg_i.ready) begin
        admit_segment(seg_i.seg_offset, seg_i.seg_length, seg_i.payload_tag);
      end
      fail_count_o <= mismatches;
      pending_o    <= due_results.size();
    end
  end

endmodule

FILE: test/sliding_window_reorder_receiver_unit_tb.sv
// testbench top for the selective-repeat receive window: clock, reset, segment stimulus,
// total-length writes and result backpressure; checking sits in srwr_window_checker
// depends on srwr_pkg, srwr_if, srwr_window_checker and the block itself
module sliding_window_reorder_receiver_unit_tb;
  import srwr_pkg::*;

  localparam int WINDOW_SLOTS  = 64;
  localparam int SEGMENT_BYTES = 1024;
  localparam int TAG_BITS      = 8;
  localparam int RANDOM_ITEMS  = 230;
  localparam int CLK_PERIOD    = 12;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int NOISE_PCT     = 25;

  // noise flavors mixed into a window burst
  typedef enum int {
    NOISE_REPEAT,
    NOISE_BEYOND,
    NOISE_OLD,
    NOISE_INVALID,
    NOISE_GARBAGE
  } noise_e;

  // arrival orders of the segments of one burst
  typedef enum int {
    ORDER_INORDER,
    ORDER_REVERSE,
    ORDER_SHUFFLE,
    ORDER_PAIRSWAP
  } order_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [OFF_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               items_sent;
  // byte count the block will have delivered once every burst so far has drained
  logic [OFF_W-1:0] stream_pos;

  srwr_seg_if #(.TAG_BITS(TAG_BITS)) seg_bus ();
  srwr_res_if #(.TAG_BITS(TAG_BITS)) res_bus ();

  sliding_window_reorder_receiver_unit #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .SEGMENT_BYTES(SEGMENT_BYTES),
    .TAG_BITS     (TAG_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .seg_i      (seg_bus),
    .res_o      (res_bus)
  );

  srwr_window_checker #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .SEGMENT_BYTES(SEGMENT_BYTES),
    .TAG_BITS     (TAG_BITS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .seg_i       (seg_bus),
    .res_i       (res_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD/2) clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(CLK_PERIOD * 300000);
    $display("tb: failure");
    $finish;
  end

  // result backpressure, redrawn every cycle at the current idle rate
  always @(posedge clk_i) begin
    res_bus.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  // one segment request: random idle cycles first, then hold valid until taken
  task automatic send_segment(input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len,
                              input logic [TAG_BITS-1:0] tag);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      seg_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg_bus.valid       <= 1'b1;
    seg_bus.seg_offset  <= off;
    seg_bus.seg_length  <= len;
    seg_bus.payload_tag <= tag;
    do @(posedge clk_i); while (!seg_bus.ready);
    items_sent++;
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic settle();
    int waited;
    waited = 0;
    seg_bus.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    // extra wait for anything the block might still emit
    repeat (8) @(posedge clk_i);
  endtask

  // only called right after settle, so the block is idle
  task automatic write_total(input logic [OFF_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // a well-formed run of count segments starting at stream_pos, all full size but the
  // tail, sent in the given order with noise requests mixed in; the run always drains
  // completely, so stream_pos can be advanced by its byte total
  task automatic send_window_burst(input int count, input order_e order,
                                   input logic [LEN_W-1:0] tail_len, input int noise_pct);
    int               perm [WINDOW_SLOTS];
    int               i;
    int               j;
    int               k;
    int               tmp;
    int               span;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    // past this distance from stream_pos nothing can land in the window
    span = (count + WINDOW_SLOTS + 2) * SEGMENT_BYTES;
    for (i = 0; i < count; i++) perm[i] = i;
    case (order)
      ORDER_REVERSE: begin
        for (i = 0; i < count; i++) perm[i] = count - 1 - i;
      end
      ORDER_SHUFFLE: begin
        for (i = count - 1; i > 0; i--) begin
          j       = $urandom_range(i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
      end
      ORDER_PAIRSWAP: begin
        for (i = 0; i + 1 < count; i += 2) begin
          tmp       = perm[i];
          perm[i]   = perm[i+1];
          perm[i+1] = tmp;
        end
      end
      default: begin
      end
    endcase
    for (i = 0; i < count; i++) begin
      if (int'($urandom_range(99)) < noise_pct) begin
        len = LEN_W'($urandom_range(2047));
        case (noise_e'($urandom_range(4)))
          NOISE_REPEAT: begin
            // resend of an earlier segment: still held gives a duplicate, already
            // released gives an old one; the tail is skipped since a short tail
            // leaves part of its slot ahead of the delivered count
            j = (i > 0) ? $urandom_range(i - 1) : 0;
            if (i > 0 && perm[j] != count - 1) begin
              off = stream_pos + perm[j] * SEGMENT_BYTES + $urandom_range(SEGMENT_BYTES - 1);
              send_segment(off, len, TAG_BITS'($urandom));
            end else begin
              send_segment('0, '0, TAG_BITS'($urandom));
            end
          end
          NOISE_BEYOND: begin
            off = stream_pos + span + $urandom_range(1 << 20);
            send_segment(off, len, TAG_BITS'($urandom));
          end
          NOISE_OLD: begin
            off = (stream_pos > 0) ? OFF_W'($urandom_range(stream_pos - 1)) : '0;
            send_segment(off, (stream_pos > 0) ? len : '0, TAG_BITS'($urandom));
          end
          NOISE_INVALID: begin
            send_segment('0, '0, TAG_BITS'($urandom));
          end
          default: begin
            // anywhere in the offset space except near the live window
            do off = $urandom; while ((off - stream_pos) < OFF_W'(span));
            send_segment(off, len, TAG_BITS'($urandom));
          end
        endcase
      end
      k   = perm[i];
      off = stream_pos + k * SEGMENT_BYTES + $urandom_range(SEGMENT_BYTES - 1);
      send_segment(off, (k == count - 1) ? tail_len : LEN_W'(SEGMENT_BYTES),
                   TAG_BITS'($urandom));
    end
    stream_pos += (count - 1) * SEGMENT_BYTES + tail_len;
  endtask

  initial begin
    int               burst_no;
    int               count;
    order_e           order;
    logic [LEN_W-1:0] tail_len;
    logic [OFF_W-1:0] burst_bytes;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    seg_bus.valid       = 1'b0;
    seg_bus.seg_offset  = '0;
    seg_bus.seg_length  = '0;
    seg_bus.payload_tag = '0;
    res_bus.ready       = 1'b0;
    send_idle_pct       = 37;
    recv_idle_pct       = 53;
    stream_pos          = '0;
    items_sent          = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, total length still at its reset value of zero so the done flag
    // is up from the start
    send_segment('0, '0, 8'h00);                            // invalid: no offset, no length
    send_segment('1, 11'h7FF, 8'hFF);                       // all ones, far beyond the window
    send_segment(WINDOW_SLOTS * SEGMENT_BYTES, 11'd1024, 8'h3C); // first slot past the window
    send_segment('0, 11'd1024, 8'h00);                      // lands on the base: release only
    stream_pos = 1024;
    send_segment('0, 11'd5, 8'h81);                         // old segment
    send_segment(stream_pos + SEGMENT_BYTES, 11'd1024, 8'hA5);      // held one slot ahead
    send_segment(stream_pos + SEGMENT_BYTES + 17, 11'd300, 8'h5A);  // duplicate of it
    send_segment(stream_pos, 11'd2047, 8'h0F);              // over-long at base, drains both
    stream_pos += 2047 + 1024;
    send_segment(stream_pos, '0, 8'hF0);                    // zero-length release at base
    settle();
    // total reached exactly on the last release, then traffic after completion
    write_total(stream_pos + 3 * SEGMENT_BYTES);
    send_window_burst(3, ORDER_REVERSE, 11'd1024, 0);
    send_segment(stream_pos - 1, 11'd64, 8'h99);            // old, after the transfer is done
    settle();
    write_total('1);
    send_window_burst(2, ORDER_INORDER, 11'd2047, 0);
    settle();

    // random part: bursts of well-formed segments with noise in between; the first one
    // fills the whole window in reverse so the last arrival drains every slot
    items_sent = 0;
    burst_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      // idling: sender-light first, then receiver-light, then none at all
      if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 37;
      end
      if (burst_no == 0) begin
        count = WINDOW_SLOTS;
        order = ORDER_REVERSE;
      end else begin
        count = ($urandom_range(9) == 0) ? $urandom_range(20, WINDOW_SLOTS)
                                         : $urandom_range(1, 10);
        order = order_e'($urandom_range(3));
      end
      tail_len = LEN_W'($urandom_range(2047));
      if (stream_pos == 0 && count == 1 && tail_len == 0) tail_len = 1;
      burst_bytes = (count - 1) * SEGMENT_BYTES + tail_len;
      // now and then retarget the total length while the block is idle
      if (burst_no == 0 || $urandom_range(2) == 0) begin
        settle();
        case ($urandom_range(3))
          0:       write_total('0);
          1:       write_total('1);
          2:       write_total($urandom);
          default: write_total(stream_pos + burst_bytes);
        endcase
      end
      send_window_burst(count, order, tail_len, NOISE_PCT);
      burst_no++;
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/srwr_pkg.sv
src/srwr_if.sv
src/srwr_ctrl.sv
src/srwr_dp.sv
src/sliding_window_reorder_receiver_unit.sv
test/srwr_window_checker.sv
test/sliding_window_reorder_receiver_unit_tb.sv
